// File: sv/sd_spi_host_sequencer_top_assert.svh
// assertion macros for the sd spi host sequencer
`ifndef SD_SPI_HOST_SEQUENCER_TOP_ASSERT_SVH
`define SD_SPI_HOST_SEQUENCER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define SSHS_ASSERT_IMPL(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SSHS_ASSERT(label, prop, msg) `SSHS_ASSERT_IMPL(label, prop, msg)
`else
`define SSHS_ASSERT_IMPL(label, prop, msg)
`define SSHS_ASSERT(label, prop, msg)
`endif
`endif

// File: sv/sshs_pkg.sv
`timescale 1ns / 1ps
package sshs_pkg;
    localparam int BLOCK_BYTES   = 512;
    localparam int POWERUP_BYTES = 12;

    localparam logic [5:0] PH_IDLE      = 6'd0;
    localparam logic [5:0] PH_POWER     = 6'd1;
    localparam logic [5:0] PH_CMD_TX    = 6'd2;
    localparam logic [5:0] PH_CMD_POLL  = 6'd3;
    localparam logic [5:0] PH_CMD_EXTRA = 6'd4;
    localparam logic [5:0] PH_CMD_TAIL  = 6'd5;
    localparam logic [5:0] PH_RD_TOKEN  = 6'd6;
    localparam logic [5:0] PH_RD_DATA   = 6'd7;
    localparam logic [5:0] PH_CRC       = 6'd8;
    localparam logic [5:0] PH_WR_DATA   = 6'd9;
    localparam logic [5:0] PH_WR_RESP   = 6'd10;
    localparam logic [5:0] PH_WR_BUSY   = 6'd11;
    localparam logic [5:0] PH_DATA_TAIL = 6'd12;

    localparam logic [3:0] K_GO_IDLE  = 4'd0;
    localparam logic [3:0] K_IF_COND  = 4'd1;
    localparam logic [3:0] K_APP      = 4'd2;
    localparam logic [3:0] K_OP_COND  = 4'd3;
    localparam logic [3:0] K_OCR      = 4'd4;
    localparam logic [3:0] K_BLOCKLEN = 4'd5;
    localparam logic [3:0] K_READ     = 4'd6;
    localparam logic [3:0] K_WRITE    = 4'd7;
    localparam logic [3:0] K_STATUS   = 4'd8;

    localparam logic [1:0] REQ_BYTE  = 2'd0;
    localparam logic [1:0] REQ_INIT  = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;
    localparam logic [1:0] REQ_WRITE = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ERR   = 2'd1;
    localparam logic [1:0] ST_PARAM = 2'd2;

    localparam logic [2:0] RA_CMD0   = 3'd0;
    localparam logic [2:0] RA_ACMD41 = 3'd1;
    localparam logic [2:0] RA_RESP   = 3'd2;
    localparam logic [2:0] RA_RDTOK  = 3'd3;
    localparam logic [2:0] RA_WRPOLL = 3'd4;

    typedef struct packed {
        logic [3:0]  cmd0_attempts;
        logic [15:0] acmd41_attempts;
        logic [7:0]  response_poll_limit;
        logic [15:0] read_token_limit;
        logic [15:0] write_poll_limit;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  drive_number;
        logic [7:0]  block_count;
        logic [31:0] sector;
        logic [7:0]  rx_byte;
        logic [7:0]  wr_byte;
    } item_t;

    typedef struct packed {
        logic        shift_now;
        logic [7:0]  tx_byte;
        logic        chip_select_low;
        logic [7:0]  read_byte;
        logic        read_valid;
        logic        wants_write_byte;
        logic        done_res;
        logic [1:0]  status;
        logic        card_ready;
    } res_t;

    function automatic logic [7:0] cmd_code(input logic [3:0] k);
        case (k)
            K_IF_COND:  cmd_code = 8'h48;
            K_APP:      cmd_code = 8'h77;
            K_OP_COND:  cmd_code = 8'h69;
            K_OCR:      cmd_code = 8'h7A;
            K_BLOCKLEN: cmd_code = 8'h50;
            K_READ:     cmd_code = 8'h51;
            K_WRITE:    cmd_code = 8'h58;
            K_STATUS:   cmd_code = 8'h4D;
            default:    cmd_code = 8'h40;
        endcase
    endfunction

    function automatic logic [31:0] cmd_arg(input logic [3:0] k);
        case (k)
            K_IF_COND:  cmd_arg = 32'h000001AA;
            K_OP_COND:  cmd_arg = 32'h40000000;
            K_BLOCKLEN: cmd_arg = 32'h00000200;
            default:    cmd_arg = 32'h0;
        endcase
    endfunction

    function automatic logic [7:0] cmd_crc(input logic [3:0] k);
        case (k)
            K_GO_IDLE: cmd_crc = 8'h95;
            K_IF_COND: cmd_crc = 8'h87;
            default:   cmd_crc = 8'h01;
        endcase
    endfunction

    function automatic logic [2:0] cmd_extra(input logic [3:0] k);
        case (k)
            K_IF_COND, K_OCR: cmd_extra = 3'd4;
            K_STATUS:         cmd_extra = 3'd1;
            default:          cmd_extra = 3'd0;
        endcase
    endfunction
endpackage

// File: sv/sd_spi_host_sequencer_top.sv
`timescale 1ns / 1ps
// SD card SPI-mode host sequencer. Each accepted input item is one SPI byte
// slot: either a request (initialize, read one block, write one block) taken
// while idle, or the card's reply byte to the last shifted byte while a request
// runs. Each reply item, and each request, yields at most one result item that
// says which byte to shift next and the chip-select level, or that the request
// finished with a status. One item per clock is accepted: the decision is one
// pass of logic from the state registers into a single output register, and
// the input side stalls only when that register is full and not taken.
// Configuration registers sit at byte addresses 0,4,8,12,16 on the APB port.
module sd_spi_host_sequencer_top
    import sshs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // req_type
    // drive_number[7:0], block_count[15:8], sector[47:16], rx_byte[55:48],
    // wr_byte[63:56]
    input  logic [63:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // shift_now[0], tx_byte[8:1], chip_select_low[9], read_byte[17:10],
    // read_valid[18], wants_write_byte[19], done_res[20], status[22:21],
    // card_ready[23]
    output logic [23:0] m_tdata
);
    cfg_t  cfg;
    item_t item;
    res_t  core_res, out_res;
    logic  core_valid, stage_ready, in_fire;

    sshs_cfg_regs u_cfg (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
    );

    assign item.req_type     = s_tuser;
    assign item.drive_number = s_tdata[7:0];
    assign item.block_count  = s_tdata[15:8];
    assign item.sector       = s_tdata[47:16];
    assign item.rx_byte      = s_tdata[55:48];
    assign item.wr_byte      = s_tdata[63:56];

    assign s_tready = stage_ready;
    assign in_fire  = s_tvalid && stage_ready;

    sshs_core u_core (
        .clk(clk), .rst_n(rst_n), .cfg(cfg), .in_fire(in_fire), .item(item),
        .res_valid(core_valid), .res(core_res)
    );

    sshs_out_stage u_out (
        .clk(clk), .rst_n(rst_n), .in_tvalid(core_valid), .in_tready(stage_ready),
        .in_res(core_res), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_res(out_res)
    );

    assign m_tdata = {out_res.card_ready, out_res.status, out_res.done_res,
                      out_res.wants_write_byte, out_res.read_valid, out_res.read_byte,
                      out_res.chip_select_low, out_res.tx_byte, out_res.shift_now};
endmodule

// File: sv/sshs_cfg_regs.sv
`timescale 1ns / 1ps
module sshs_cfg_regs
    import sshs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);
    cfg_t cfg_reg;
    logic wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[4:2];
    assign cfg    = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cmd0_attempts       <= 4'd5;
            cfg_reg.acmd41_attempts     <= 16'd20000;
            cfg_reg.response_poll_limit <= 8'd20;
            cfg_reg.read_token_limit    <= 16'd40000;
            cfg_reg.write_poll_limit    <= 16'd10000;
        end
        else if (wr_en && paddr[1:0] == 2'b00)
        begin
            case (idx)
                RA_CMD0:   cfg_reg.cmd0_attempts       <= pwdata[3:0];
                RA_ACMD41: cfg_reg.acmd41_attempts     <= pwdata[15:0];
                RA_RESP:   cfg_reg.response_poll_limit <= pwdata[7:0];
                RA_RDTOK:  cfg_reg.read_token_limit    <= pwdata[15:0];
                RA_WRPOLL: cfg_reg.write_poll_limit    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        case (idx)
            RA_CMD0:   prdata = {28'd0, cfg_reg.cmd0_attempts};
            RA_ACMD41: prdata = {16'd0, cfg_reg.acmd41_attempts};
            RA_RESP:   prdata = {24'd0, cfg_reg.response_poll_limit};
            RA_RDTOK:  prdata = {16'd0, cfg_reg.read_token_limit};
            RA_WRPOLL: prdata = {16'd0, cfg_reg.write_poll_limit};
            default:   prdata = 32'd0;
        endcase
    end
endmodule

// File: sv/sshs_core.sv
`timescale 1ns / 1ps
module sshs_core
    import sshs_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  logic  in_fire,
    input  item_t item,
    output logic  res_valid,
    output res_t  res
);
    `include "sd_spi_host_sequencer_top_assert.svh"

    logic [5:0]  phase_reg, phase_next;
    logic [9:0]  bidx_reg, bidx_next;
    logic [15:0] poll_reg, poll_next;
    logic [15:0] retry_reg, retry_next;
    logic [39:0] stash_reg, stash_next;
    logic        init_reg, init_next;
    logic [31:0] sector_reg, sector_next;
    logic [3:0]  cmd_reg, cmd_next;

    logic        emit;
    res_t        r;
    logic [15:0] poll_inc, retry_inc;
    logic [15:0] lim_resp, lim_rd, lim_wr, lim_cmd0, lim_a41;
    logic [39:0] stash_sh;
    logic [31:0] arg;
    logic [7:0]  cbyte;
    logic        ok;
    logic [7:0]  r1, b0, b1, b3;
    logic [3:0]  k_start;
    logic        do_start;

    assign poll_inc  = poll_reg + 16'd1;
    assign retry_inc = retry_reg + 16'd1;
    assign lim_resp  = (cfg.response_poll_limit == 8'd0) ? 16'd1
                                                        : {8'd0, cfg.response_poll_limit};
    assign lim_rd    = (cfg.read_token_limit == 16'd0) ? 16'd1 : cfg.read_token_limit;
    assign lim_wr    = (cfg.write_poll_limit == 16'd0) ? 16'd1 : cfg.write_poll_limit;
    assign lim_cmd0  = (cfg.cmd0_attempts == 4'd0) ? 16'd1 : {12'd0, cfg.cmd0_attempts};
    assign lim_a41   = (cfg.acmd41_attempts == 16'd0) ? 16'd1 : cfg.acmd41_attempts;
    assign stash_sh  = {stash_reg[31:0], item.rx_byte};
    assign arg       = (cmd_reg == K_READ || cmd_reg == K_WRITE) ? sector_reg
                                                                 : cmd_arg(cmd_reg);
    assign r1 = stash_reg[7:0];
    assign b0 = stash_reg[39:32];
    assign b1 = stash_reg[31:24];
    assign b3 = stash_reg[15:8];

    // command byte for the current index
    always_comb
    begin
        case (bidx_reg[2:0])
            3'd1:    cbyte = arg[31:24];
            3'd2:    cbyte = arg[23:16];
            3'd3:    cbyte = arg[15:8];
            3'd4:    cbyte = arg[7:0];
            default: cbyte = cmd_crc(cmd_reg);
        endcase
    end

    // next state and result
    always_comb
    begin
        phase_next  = phase_reg;
        bidx_next   = bidx_reg;
        poll_next   = poll_reg;
        retry_next  = retry_reg;
        stash_next  = stash_reg;
        init_next   = init_reg;
        sector_next = sector_reg;
        cmd_next    = cmd_reg;
        emit        = 1'b0;
        do_start    = 1'b0;
        k_start     = K_GO_IDLE;
        ok          = 1'b1;
        r = '0;
        r.tx_byte = 8'hFF;

        if (in_fire)
        begin
            if (phase_reg == PH_IDLE)
            begin
                if (item.req_type != REQ_BYTE)
                begin
                    emit = 1'b1;
                    if (item.drive_number != 8'd0)
                    begin
                        r.done_res = 1'b1; r.status = ST_PARAM;
                    end
                    else if (item.req_type == REQ_INIT)
                    begin
                        retry_next = '0; bidx_next = 10'd1; phase_next = PH_POWER;
                        r.shift_now = 1'b1;
                    end
                    else if (item.block_count != 8'd1)
                    begin
                        r.done_res = 1'b1; r.status = ST_PARAM;
                    end
                    else
                    begin
                        sector_next = item.sector;
                        do_start = 1'b1;
                        k_start = (item.req_type == REQ_READ) ? K_READ : K_WRITE;
                    end
                end
            end
            else if (item.req_type == REQ_BYTE)
            begin
                emit = 1'b1;
                case (phase_reg)
                    PH_POWER:
                    begin
                        if (bidx_reg < 10'(POWERUP_BYTES))
                        begin
                            bidx_next = bidx_reg + 10'd1; r.shift_now = 1'b1;
                        end
                        else
                        begin
                            do_start = 1'b1; k_start = K_GO_IDLE;
                        end
                    end
                    PH_CMD_TX:
                    begin
                        r.shift_now = 1'b1; r.chip_select_low = 1'b1;
                        if (bidx_reg < 10'd6)
                        begin
                            r.tx_byte = cbyte; bidx_next = bidx_reg + 10'd1;
                        end
                        else
                        begin
                            phase_next = PH_CMD_POLL; poll_next = '0;
                        end
                    end
                    PH_CMD_POLL:
                    begin
                        poll_next = poll_inc;
                        if (!item.rx_byte[7])
                        begin
                            stash_next = stash_sh;
                            bidx_next = {7'd0, cmd_extra(cmd_reg)};
                            r.shift_now = 1'b1;
                            if (cmd_extra(cmd_reg) != 3'd0)
                            begin
                                phase_next = PH_CMD_EXTRA; r.chip_select_low = 1'b1;
                            end
                            else
                                phase_next = PH_CMD_TAIL;
                        end
                        else if (poll_inc >= lim_resp)
                            ok = 1'b0;
                        else
                        begin
                            r.shift_now = 1'b1; r.chip_select_low = 1'b1;
                        end
                    end
                    PH_CMD_EXTRA:
                    begin
                        stash_next = stash_sh;
                        r.shift_now = 1'b1;
                        if (bidx_reg > 10'd1)
                        begin
                            bidx_next = bidx_reg - 10'd1; r.chip_select_low = 1'b1;
                        end
                        else
                        begin
                            bidx_next = '0; phase_next = PH_CMD_TAIL;
                        end
                    end
                    PH_CMD_TAIL: ;
                    PH_RD_TOKEN:
                    begin
                        poll_next = poll_inc;
                        if (item.rx_byte == 8'hFE)
                        begin
                            phase_next = PH_RD_DATA; bidx_next = '0;
                            r.shift_now = 1'b1; r.chip_select_low = 1'b1;
                        end
                        else if (poll_inc >= lim_rd)
                        begin
                            r.done_res = 1'b1; r.status = ST_ERR;
                        end
                        else
                        begin
                            r.shift_now = 1'b1; r.chip_select_low = 1'b1;
                        end
                    end
                    PH_RD_DATA:
                    begin
                        r.read_valid = 1'b1; r.read_byte = item.rx_byte;
                        r.shift_now = 1'b1; r.chip_select_low = 1'b1;
                        bidx_next = bidx_reg + 10'd1;
                        if (bidx_reg == 10'(BLOCK_BYTES - 1))
                        begin
                            phase_next = PH_CRC; bidx_next = 10'd1;
                        end
                    end
                    PH_CRC:
                    begin
                        r.shift_now = 1'b1;
                        if (bidx_reg < 10'd2)
                        begin
                            bidx_next = bidx_reg + 10'd1; r.chip_select_low = 1'b1;
                        end
                        else if (cmd_reg == K_READ)
                            phase_next = PH_DATA_TAIL;
                        else
                        begin
                            phase_next = PH_WR_RESP; poll_next = '0;
                            r.chip_select_low = 1'b1;
                        end
                    end
                    PH_WR_DATA:
                    begin
                        bidx_next = bidx_reg + 10'd1;
                        r.shift_now = 1'b1; r.chip_select_low = 1'b1;
                        r.tx_byte = item.wr_byte;
                        if (bidx_reg != 10'(BLOCK_BYTES - 1))
                            r.wants_write_byte = 1'b1;
                        else
                        begin
                            phase_next = PH_CRC; bidx_next = '0;
                        end
                    end
                    PH_WR_RESP:
                    begin
                        poll_next = poll_inc;
                        if (item.rx_byte != 8'hFF)
                        begin
                            if (item.rx_byte[4:0] == 5'h05)
                            begin
                                phase_next = PH_WR_BUSY; poll_next = '0;
                                r.shift_now = 1'b1; r.chip_select_low = 1'b1;
                            end
                            else
                            begin
                                r.done_res = 1'b1; r.status = ST_ERR;
                            end
                        end
                        else if (poll_inc >= lim_wr)
                        begin
                            r.done_res = 1'b1; r.status = ST_ERR;
                        end
                        else
                        begin
                            r.shift_now = 1'b1; r.chip_select_low = 1'b1;
                        end
                    end
                    PH_WR_BUSY:
                    begin
                        poll_next = poll_inc;
                        if (item.rx_byte != 8'h00)
                        begin
                            phase_next = PH_DATA_TAIL; r.shift_now = 1'b1;
                        end
                        else if (poll_inc >= lim_wr)
                        begin
                            r.done_res = 1'b1; r.status = ST_ERR;
                        end
                        else
                        begin
                            r.shift_now = 1'b1; r.chip_select_low = 1'b1;
                        end
                    end
                    PH_DATA_TAIL:
                    begin
                        if (cmd_reg == K_READ)
                            r.done_res = 1'b1;
                        else
                        begin
                            do_start = 1'b1; k_start = K_STATUS;
                        end
                    end
                    default:
                    begin
                        r.done_res = 1'b1; r.status = ST_ERR;
                    end
                endcase

                // end of command handling
                if ((phase_reg == PH_CMD_TAIL) || !ok)
                begin
                    if (cmd_reg == K_GO_IDLE)
                    begin
                        if (ok && r1 <= 8'd1)
                        begin
                            do_start = 1'b1; k_start = K_IF_COND;
                        end
                        else
                        begin
                            retry_next = retry_inc;
                            if (retry_inc >= lim_cmd0)
                            begin
                                r.done_res = 1'b1; r.status = ST_ERR;
                            end
                            else
                            begin
                                do_start = 1'b1; k_start = K_GO_IDLE;
                            end
                        end
                    end
                    else if (!ok)
                    begin
                        r.done_res = 1'b1; r.status = ST_ERR;
                    end
                    else
                    begin
                        case (cmd_reg)
                            K_IF_COND:
                                if (b0 > 8'd1 || b3[3:0] != 4'h1 || r1 != 8'hAA)
                                begin
                                    r.done_res = 1'b1; r.status = ST_ERR;
                                end
                                else
                                begin
                                    retry_next = '0; do_start = 1'b1; k_start = K_APP;
                                end
                            K_APP:
                                if (r1 > 8'd1)
                                begin
                                    r.done_res = 1'b1; r.status = ST_ERR;
                                end
                                else
                                begin
                                    do_start = 1'b1; k_start = K_OP_COND;
                                end
                            K_OP_COND:
                                if (r1 == 8'd0)
                                begin
                                    do_start = 1'b1; k_start = K_OCR;
                                end
                                else
                                begin
                                    retry_next = retry_inc;
                                    if (retry_inc >= lim_a41)
                                    begin
                                        r.done_res = 1'b1; r.status = ST_ERR;
                                    end
                                    else
                                    begin
                                        do_start = 1'b1; k_start = K_APP;
                                    end
                                end
                            K_OCR:
                                if (b0 != 8'd0)
                                begin
                                    r.done_res = 1'b1; r.status = ST_ERR;
                                end
                                else if (!b1[6] && b1[7])
                                begin
                                    do_start = 1'b1; k_start = K_BLOCKLEN;
                                end
                                else
                                begin
                                    init_next = 1'b1; r.done_res = 1'b1;
                                end
                            K_BLOCKLEN:
                                if (r1 != 8'd0)
                                begin
                                    r.done_res = 1'b1; r.status = ST_ERR;
                                end
                                else
                                begin
                                    init_next = 1'b1; r.done_res = 1'b1;
                                end
                            K_READ:
                                if (r1 != 8'd0)
                                begin
                                    r.done_res = 1'b1; r.status = ST_ERR;
                                end
                                else
                                begin
                                    phase_next = PH_RD_TOKEN; poll_next = '0;
                                    r.shift_now = 1'b1; r.chip_select_low = 1'b1;
                                end
                            K_WRITE:
                                if (r1 != 8'd0)
                                begin
                                    r.done_res = 1'b1; r.status = ST_ERR;
                                end
                                else
                                begin
                                    phase_next = PH_WR_DATA; bidx_next = '0;
                                    r.shift_now = 1'b1; r.chip_select_low = 1'b1;
                                    r.tx_byte = 8'hFE; r.wants_write_byte = 1'b1;
                                end
                            K_STATUS:
                            begin
                                r.done_res = 1'b1;
                                r.status = (stash_reg[15:0] != 16'd0) ? ST_ERR : ST_OK;
                            end
                            default:
                            begin
                                r.done_res = 1'b1; r.status = ST_ERR;
                            end
                        endcase
                    end
                end
            end

            // command start shared by all paths
            if (do_start)
            begin
                cmd_next   = k_start;
                stash_next = '1;
                bidx_next  = 10'd1;
                phase_next = PH_CMD_TX;
                r.shift_now = 1'b1; r.chip_select_low = 1'b1;
                r.tx_byte = cmd_code(k_start);
            end
            if (r.done_res)
            begin
                phase_next = PH_IDLE;
                r.shift_now = 1'b0; r.tx_byte = 8'hFF; r.chip_select_low = 1'b0;
            end
        end
        r.card_ready = init_next;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            bidx_reg   <= '0;
            poll_reg   <= '0;
            retry_reg  <= '0;
            stash_reg  <= '1;
            init_reg   <= 1'b0;
            sector_reg <= '0;
            cmd_reg    <= K_GO_IDLE;
        end
        else
        begin
            phase_reg  <= phase_next;
            bidx_reg   <= bidx_next;
            poll_reg   <= poll_next;
            retry_reg  <= retry_next;
            stash_reg  <= stash_next;
            init_reg   <= init_next;
            sector_reg <= sector_next;
            cmd_reg    <= cmd_next;
        end
    end

    assign res_valid = emit;
    assign res       = r;

    `SSHS_ASSERT(a_done_idle, (res_valid && res.done_res) |=> (phase_reg == PH_IDLE),
        "done result must return to idle")
    `SSHS_ASSERT(a_done_noshift, (res_valid && res.done_res) |-> !res.shift_now,
        "done result must not shift")
    `SSHS_ASSERT(a_ready_sticky, init_reg |=> init_reg, "card ready dropped")
    `SSHS_ASSERT(a_bidx_range, (phase_reg == PH_RD_DATA) |-> (bidx_reg <= 10'(BLOCK_BYTES - 1)),
        "read index out of range")
endmodule

// File: sv/sshs_out_stage.sv
`timescale 1ns / 1ps
module sshs_out_stage
    import sshs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_tvalid,
    output logic in_tready,
    input  res_t in_res,
    output logic m_tvalid,
    input  logic m_tready,
    output res_t m_res
);
    logic valid_reg;
    res_t data_reg;

    // one result register, refilled in the cycle it drains
    assign in_tready = !valid_reg || m_tready;
    assign m_tvalid  = valid_reg;
    assign m_res     = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_tready)
            valid_reg <= in_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (in_tready && in_tvalid)
            data_reg <= in_res;
    end
endmodule
